FILE: rtl/core/vas_pkg.sv
// Package for the viscous advection stencil step core.
// Holds grid/value constants, register indexes, state and op enums and a saturation helper.
// No dependencies.
package vas_pkg;

  localparam int GridPoints = 64;
  localparam int IdxBits    = 6;
  localparam int ValueBits  = 32;
  localparam int AddrBits   = 5;

  typedef logic signed [ValueBits-1:0] val_t;

  typedef enum logic [2:0] {
    REG_BOUNDARY_MODE  = 3'd0,
    REG_BOUNDARY_VALUE = 3'd1,
    REG_VELOCITY_MODE  = 3'd2,
    REG_LIN_VELOCITY   = 3'd3,
    REG_SCHEME_MODE    = 3'd4,
    REG_RATIO_DT_DX    = 3'd5,
    REG_DIFFUSION_COEF = 3'd6,
    REG_LEAPFROG_SCALE = 3'd7
  } reg_idx_t;

  // Sequencer states: clear pass, three reads and a capture, then a chain of
  // shared-ALU steps, write-back and output transfer.
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_A, ST_RD_B, ST_RD_C, ST_CAP,
    ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6, ST_F7, ST_F8,
    ST_L1, ST_L2, ST_L3, ST_L4, ST_L5, ST_L6, ST_L7,
    ST_WB,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB
  } op_t;

  localparam logic signed [ValueBits-1:0] QHalf = ValueBits'(32768);

  function automatic val_t sat_wide(input logic signed [ValueBits+1:0] x);
    logic signed [ValueBits+1:0] hi;
    logic signed [ValueBits+1:0] lo;
    hi = (ValueBits+2)'({1'b0, {(ValueBits-1){1'b1}}});
    lo = -hi - 1;
    if (x > hi) return hi[ValueBits-1:0];
    else if (x < lo) return lo[ValueBits-1:0];
    else return x[ValueBits-1:0];
  endfunction

endpackage

FILE: rtl/core/vas_alu.sv
// Shared arithmetic unit: Q16.16 rounded saturating multiply, saturating add/sub.
// Result registered; one operation per cycle. Uses vas_pkg.
module vas_alu (
  input  logic               clk,
  input  vas_pkg::op_t       op,
  input  vas_pkg::val_t      a,
  input  vas_pkg::val_t      b,
  output vas_pkg::val_t      y
);

  localparam int W = vas_pkg::ValueBits;

  logic        neg;
  logic [W-1:0] ua;
  logic [W-1:0] ub;
  logic [2*W-1:0] prod;
  logic [2*W-1:0] rnd;
  logic [2*W-1:0] mag;
  logic [2*W-1:0] lim;
  vas_pkg::val_t  mres;
  vas_pkg::val_t  y_next;

  always_comb begin
    neg  = a[W-1] ^ b[W-1];
    ua   = a[W-1] ? W'(-a) : a;
    ub   = b[W-1] ? W'(-b) : b;
    prod = ua * ub;
    rnd  = prod + (2*W)'(32768);
    mag  = rnd >> 16;
    lim  = (2*W)'({1'b0, {(W-1){1'b1}}});
    if (neg) begin
      if (mag > lim + 1) mres = {1'b1, {(W-1){1'b0}}};
      else mres = W'(-mag);
    end else begin
      if (mag > lim) mres = {1'b0, {(W-1){1'b1}}};
      else mres = mag[W-1:0];
    end
    case (op)
      vas_pkg::OP_MUL: y_next = mres;
      vas_pkg::OP_ADD: y_next = vas_pkg::sat_wide((W+2)'(a) + (W+2)'(b));
      default:         y_next = vas_pkg::sat_wide((W+2)'(a) - (W+2)'(b));
    endcase
  end

  always_ff @(posedge clk) begin
    y <= y_next;
  end

endmodule

FILE: rtl/core/viscous_advection_stencil_step_core.sv
// Viscous advection (Burgers) one-step stencil core, Q16.16, iterative datapath.
// Load: writes the point and clears its previous value; s_tready stays high. Advance:
//   accepted while idle, then per point reads and a capture, 8 forward or 7 leapfrog
//   shared-ALU ops (none on a fixed boundary point), write-back and output transfer;
//   output stalls hold the walk.
// rst (sync, active high): registers to defaults, then a clear pass over all 64 points
//   zeroes the previous field before s_tready first rises. Depends on vas_pkg and vas_alu.
module viscous_advection_stencil_step_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [5:0] point_index, [37:6] sample_value, zero pad
  input  logic        s_tuser,   // kind: 0 load, 1 advance
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [5:0] out_index, [37:6] new_value, zero pad
  output logic        m_tlast,   // last_point
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [vas_pkg::AddrBits-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int W  = vas_pkg::ValueBits;
  localparam int IB = vas_pkg::IdxBits;
  localparam int N  = vas_pkg::GridPoints;

  // configuration registers
  logic          boundary_mode, velocity_mode, scheme_mode;
  vas_pkg::val_t boundary_value, adv_velocity, ratio_dt_dx, diffusion_coef, leapfrog_scale;

  logic cfg_wr;
  vas_pkg::reg_idx_t cfg_idx;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign cfg_idx = vas_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      boundary_mode   <= 1'b1;
      boundary_value  <= '0;
      velocity_mode   <= 1'b0;
      adv_velocity    <= W'(655360);
      scheme_mode     <= 1'b0;
      ratio_dt_dx     <= W'(65536);
      diffusion_coef  <= W'(131);
      leapfrog_scale  <= W'(65405);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        vas_pkg::REG_BOUNDARY_MODE:  boundary_mode   <= pwdata[0];
        vas_pkg::REG_BOUNDARY_VALUE: boundary_value  <= pwdata;
        vas_pkg::REG_VELOCITY_MODE:  velocity_mode   <= pwdata[0];
        vas_pkg::REG_LIN_VELOCITY:   adv_velocity    <= pwdata;
        vas_pkg::REG_SCHEME_MODE:    scheme_mode     <= pwdata[0];
        vas_pkg::REG_RATIO_DT_DX:    ratio_dt_dx     <= pwdata;
        vas_pkg::REG_DIFFUSION_COEF: diffusion_coef  <= pwdata;
        default:                     leapfrog_scale  <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      vas_pkg::REG_BOUNDARY_MODE:  prdata = {31'd0, boundary_mode};
      vas_pkg::REG_BOUNDARY_VALUE: prdata = boundary_value;
      vas_pkg::REG_VELOCITY_MODE:  prdata = {31'd0, velocity_mode};
      vas_pkg::REG_LIN_VELOCITY:   prdata = adv_velocity;
      vas_pkg::REG_SCHEME_MODE:    prdata = {31'd0, scheme_mode};
      vas_pkg::REG_RATIO_DT_DX:    prdata = ratio_dt_dx;
      vas_pkg::REG_DIFFUSION_COEF: prdata = diffusion_coef;
      default:                     prdata = leapfrog_scale;
    endcase
  end

  // Field storage: current and previous, one read port each, registered data.
  // An advance walks points in order; point i moves cur[i] into prev[i] and
  // writes its new value into cur[i]. So during point i, cur[i+1..] still hold
  // the old current field and prev[..i-1] already hold it. The older field
  // after a leapfrog shift is the old prev[i], read before it is overwritten,
  // so it needs no storage of its own.
  logic [W-1:0] cur_mem  [N];
  logic [W-1:0] prev_mem [N];
  logic [W-1:0] cur_rd, prev_rd;
  logic [IB-1:0] cur_ra, prev_ra;
  logic          first_pending;

  vas_pkg::state_t state, state_next;
  logic [IB-1:0] pt;
  logic          fwd;
  vas_pkg::val_t c_v, p_v, m_v, q_v, acc, tmp, nv;
  vas_pkg::val_t alu_y, alu_a, alu_b;
  vas_pkg::op_t  alu_op;

  logic s_fire, m_fire, is_bnd, last_pt, wr_new;
  logic [IB-1:0] ld_idx;
  logic [W-1:0]  ld_val;
  assign s_tready = (state == vas_pkg::ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign m_fire   = m_tvalid && m_tready;
  assign last_pt  = (pt == IB'(N-1));
  assign is_bnd   = !boundary_mode && (pt == '0 || last_pt);
  assign ld_idx   = s_tdata[IB-1:0];
  assign ld_val   = s_tdata[W+IB-1:IB];
  assign wr_new   = (state == vas_pkg::ST_EMIT) && (!m_tvalid || m_tready);

  // Read addresses: A reads p and q, B the right neighbor, C the left one.
  // The right neighbor of the last point and the left one of point 0 wrap.
  always_comb begin
    cur_ra  = pt;
    prev_ra = pt;
    unique case (state)
      vas_pkg::ST_RD_B: begin
        cur_ra  = pt + 1'b1;
        prev_ra = '0;
      end
      vas_pkg::ST_RD_C: begin
        cur_ra  = IB'(N-1);
        prev_ra = pt - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    cur_rd  <= cur_mem[cur_ra];
    prev_rd <= prev_mem[prev_ra];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      vas_pkg::ST_CLEAR: if (last_pt) state_next = vas_pkg::ST_IDLE;
      vas_pkg::ST_IDLE: if (s_fire && s_tuser) state_next = vas_pkg::ST_RD_A;
      vas_pkg::ST_RD_A: state_next = vas_pkg::ST_RD_B;
      vas_pkg::ST_RD_B: state_next = vas_pkg::ST_RD_C;
      vas_pkg::ST_RD_C: state_next = vas_pkg::ST_CAP;
      vas_pkg::ST_CAP:  state_next = is_bnd ? vas_pkg::ST_WB
                                   : (fwd ? vas_pkg::ST_F1 : vas_pkg::ST_L1);
      vas_pkg::ST_F1: state_next = vas_pkg::ST_F2;
      vas_pkg::ST_F2: state_next = vas_pkg::ST_F3;
      vas_pkg::ST_F3: state_next = vas_pkg::ST_F4;
      vas_pkg::ST_F4: state_next = vas_pkg::ST_F5;
      vas_pkg::ST_F5: state_next = vas_pkg::ST_F6;
      vas_pkg::ST_F6: state_next = vas_pkg::ST_F7;
      vas_pkg::ST_F7: state_next = vas_pkg::ST_F8;
      vas_pkg::ST_F8: state_next = vas_pkg::ST_WB;
      vas_pkg::ST_L1: state_next = vas_pkg::ST_L2;
      vas_pkg::ST_L2: state_next = vas_pkg::ST_L3;
      vas_pkg::ST_L3: state_next = vas_pkg::ST_L4;
      vas_pkg::ST_L4: state_next = vas_pkg::ST_L5;
      vas_pkg::ST_L5: state_next = vas_pkg::ST_L6;
      vas_pkg::ST_L6: state_next = vas_pkg::ST_L7;
      vas_pkg::ST_L7: state_next = vas_pkg::ST_WB;
      vas_pkg::ST_WB: state_next = vas_pkg::ST_EMIT;
      vas_pkg::ST_EMIT: if (!m_tvalid || m_tready)
        state_next = last_pt ? vas_pkg::ST_IDLE : vas_pkg::ST_RD_A;
      default: state_next = vas_pkg::ST_IDLE;
    endcase
  end

  // ALU operand selection. Operand regs: c_v=p, p_v=pp, m_v=pm, q_v=q.
  // alu_y holds the result of the op issued in the state before.
  vas_pkg::val_t vel;
  assign vel = velocity_mode ? c_v : adv_velocity;
  always_comb begin
    alu_op = vas_pkg::OP_MUL;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state)
      // forward: h=0.5*dtdx; a=h*v; d=pp-pm; adv=a*d; p-adv; g=0.5*c1;
      //   dif=g*s (s latched in acc); new=(p-adv)+dif
      vas_pkg::ST_F1: begin alu_a = vas_pkg::QHalf; alu_b = ratio_dt_dx; end
      vas_pkg::ST_F2: begin alu_a = alu_y; alu_b = vel; end
      vas_pkg::ST_F3: begin alu_op = vas_pkg::OP_SUB; alu_a = p_v; alu_b = m_v; end
      vas_pkg::ST_F4: begin alu_a = tmp; alu_b = alu_y; end
      vas_pkg::ST_F5: begin alu_op = vas_pkg::OP_SUB; alu_a = c_v; alu_b = alu_y; end
      vas_pkg::ST_F6: begin alu_a = vas_pkg::QHalf; alu_b = diffusion_coef; end
      vas_pkg::ST_F7: begin alu_a = alu_y; alu_b = acc; end
      vas_pkg::ST_F8: begin alu_op = vas_pkg::OP_ADD; alu_a = tmp; alu_b = alu_y; end
      // leapfrog: d=pp-pm; w=v*d; u=dtdx*w; t=c1*s; q+t; (q+t)-u; c0*r
      vas_pkg::ST_L1: begin alu_op = vas_pkg::OP_SUB; alu_a = p_v; alu_b = m_v; end
      vas_pkg::ST_L2: begin alu_a = vel; alu_b = alu_y; end
      vas_pkg::ST_L3: begin alu_a = ratio_dt_dx; alu_b = alu_y; end
      vas_pkg::ST_L4: begin alu_a = diffusion_coef; alu_b = acc; end
      vas_pkg::ST_L5: begin alu_op = vas_pkg::OP_ADD; alu_a = q_v; alu_b = alu_y; end
      vas_pkg::ST_L6: begin alu_op = vas_pkg::OP_SUB; alu_a = alu_y; alu_b = tmp; end
      vas_pkg::ST_L7: begin alu_a = leapfrog_scale; alu_b = alu_y; end
      default: ;
    endcase
  end

  vas_alu u_alu (
    .clk (clk),
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .y   (alu_y)
  );

  // Three-term sums are exact in two extra bits, then saturated.
  logic signed [W+1:0] s3;
  always_comb begin
    if (fwd) s3 = (W+2)'(p_v) + (W+2)'(m_v) - ((W+2)'(c_v) <<< 1);
    else     s3 = (W+2)'(p_v) + (W+2)'(m_v) - (W+2)'(q_v);
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      vas_pkg::ST_RD_B: begin
        c_v <= cur_rd;
        q_v <= prev_rd;
      end
      vas_pkg::ST_RD_C: p_v <= last_pt ? prev_rd : cur_rd;
      vas_pkg::ST_CAP:  m_v <= (pt == '0) ? cur_rd : prev_rd;
      vas_pkg::ST_F1, vas_pkg::ST_L1: acc <= vas_pkg::sat_wide(s3);
      vas_pkg::ST_F3, vas_pkg::ST_F6, vas_pkg::ST_L4: tmp <= alu_y;
      vas_pkg::ST_WB: nv <= is_bnd ? boundary_value : alu_y;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (m_fire && !wr_new) begin
      m_tvalid <= 1'b0;
    end else if (wr_new) begin
      m_tvalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_new) begin
      m_tdata <= {2'b00, nv, pt};
      m_tlast <= last_pt;
    end
  end

  // control: point counter, mode, first-step flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= vas_pkg::ST_CLEAR;
      pt            <= '0;
      fwd           <= 1'b1;
      first_pending <= 1'b1;
    end else begin
      state <= state_next;
      if (state == vas_pkg::ST_CLEAR) pt <= last_pt ? '0 : pt + 1'b1;
      if (s_fire && !s_tuser) first_pending <= 1'b1;
      if (s_fire && s_tuser) begin
        fwd           <= first_pending || !scheme_mode;
        first_pending <= 1'b0;
        pt            <= '0;
      end
      if (wr_new && !last_pt) pt <= pt + 1'b1;
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (state == vas_pkg::ST_CLEAR) prev_mem[pt] <= '0;
    else if (s_fire && !s_tuser) prev_mem[ld_idx] <= '0;
    else if (wr_new) prev_mem[pt] <= c_v;
  end

  always_ff @(posedge clk) begin
    if (s_fire && !s_tuser) cur_mem[ld_idx] <= ld_val;
    else if (wr_new) cur_mem[pt] <= nv;
  end

  // assertions
  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    (state != vas_pkg::ST_IDLE) |-> !s_tready)
    else $error("ready while busy");
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[5:0] == IB'(N-1)))
    else $error("last flag on wrong point");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("output changed while stalled");
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("valid dropped while stalled");

endmodule

FILE: bench/viscous_advection_stencil_step_core_tb.sv
// Testbench for viscous_advection_stencil_step_core: stream driver/monitor with a
// bit-accurate Q16.16 grid predictor, APB register writes between phases.
// Depends on vas_pkg and the core RTL.
`timescale 1ns / 1ps

module viscous_advection_stencil_step_core_tb;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // [5:0] point_index, [37:6] sample_value, zero pad
  logic        s_tuser;   // kind: 0 load, 1 advance
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [5:0] out_index, [37:6] new_value, zero pad
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  viscous_advection_stencil_step_core u_dut (.*);

  localparam int GridPoints = vas_pkg::GridPoints;
  localparam bit KIND_LOAD    = 1'b0;
  localparam bit KIND_ADVANCE = 1'b1;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  typedef struct packed {
    logic        kind;
    logic [5:0]  idx;
    logic [31:0] val;
  } grid_cmd_t;

  typedef struct packed {
    logic [5:0]  idx;
    logic [31:0] val;
    logic        last;
  } point_out_t;

  grid_cmd_t  cmd_q[$];
  point_out_t point_q[$];
  int         err_cnt;
  int         send_idle_pct;
  int         recv_stall_pct;
  logic       hold_arm;
  int         hold_left;

  // register mirror
  longint bnd_mode, bnd_val, vel_mode, lin_vel, sch_mode, dtdx, dcoef, lscale;
  // grid state
  longint cur_f[GridPoints];
  longint prev_f[GridPoints];
  longint old_f[GridPoints];
  bit     first_pending;

  always #5 clk = ~clk;

  function automatic longint clamp(longint x);
    return x > VMAX ? VMAX : (x < VMIN ? VMIN : x);
  endfunction

  // exact product, >>16 rounding half away from zero, saturate
  function automatic longint qmul(longint a, longint b);
    longint p;
    longint mag;
    p = a * b;
    mag = p < 0 ? -p : p;
    mag = (mag + 64'sd32768) >>> 16;
    return clamp(p < 0 ? -mag : mag);
  endfunction

  function automatic longint fwd_point(longint p, longint pp, longint pm);
    longint v;
    longint adv;
    longint dif;
    v   = vel_mode ? p : lin_vel;
    adv = qmul(qmul(qmul(32768, dtdx), v), clamp(pp - pm));
    dif = qmul(qmul(32768, dcoef), clamp(pp + pm - 2 * p));
    return clamp(clamp(p - adv) + dif);
  endfunction

  function automatic longint leap_point(longint q, longint p, longint pp, longint pm);
    longint v;
    longint t;
    longint u;
    v = vel_mode ? p : lin_vel;
    t = qmul(dcoef, clamp(pp + pm - q));
    u = qmul(dtdx, qmul(v, clamp(pp - pm)));
    return qmul(lscale, clamp(clamp(q + t) - u));
  endfunction

  // Applies one accepted command to the grid copy and queues the points it emits.
  task automatic step_grid(grid_cmd_t c);
    bit     fwd;
    longint nv;
    point_out_t o;
    if (c.kind == KIND_LOAD) begin
      cur_f[c.idx]  = longint'(signed'(c.val));
      prev_f[c.idx] = 0;
      old_f[c.idx]  = 0;
      first_pending = 1'b1;
      return;
    end
    fwd = first_pending || sch_mode == 0;
    first_pending = 1'b0;
    for (int i = 0; i < GridPoints; i++) begin
      if (!fwd) old_f[i] = prev_f[i];
      prev_f[i] = cur_f[i];
    end
    for (int i = 0; i < GridPoints; i++) begin
      int ip;
      int im;
      ip = (i + 1) % GridPoints;
      im = (i + GridPoints - 1) % GridPoints;
      if (bnd_mode == 0 && (i == 0 || i == GridPoints - 1)) nv = bnd_val;
      else if (fwd) nv = fwd_point(prev_f[i], prev_f[ip], prev_f[im]);
      else nv = leap_point(old_f[i], prev_f[i], prev_f[ip], prev_f[im]);
      cur_f[i] = nv;
      o.idx  = i[5:0];
      o.val  = nv[31:0];
      o.last = (i == GridPoints - 1);
      point_q.push_back(o);
    end
  endtask

  // Driver: offers queued commands, predicts each one on its transfer.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) step_grid(grid_cmd_t'({s_tuser, s_tdata[5:0], s_tdata[37:6]}));
      if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        grid_cmd_t c;
        c = cmd_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= c.kind;
        s_tdata  <= {2'b00, c.val, c.idx};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so the core backs up onto its input.
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_arm) hold_left <= 3000;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Monitor: random stalls, compares every transfer with the oldest predicted point.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      if (m_tvalid && m_tready) begin
        if (point_q.size() == 0) begin
          $error("unexpected point out_index=%0d", m_tdata[5:0]);
          err_cnt++;
        end else begin
          point_out_t e;
          e = point_q.pop_front();
          if (m_tdata[5:0] !== e.idx) begin
            $error("out_index exp %0d got %0d", e.idx, m_tdata[5:0]);
            err_cnt++;
          end
          if (m_tdata[37:6] !== e.val) begin
            $error("new_value exp %0d got %0d", signed'(e.val), signed'(m_tdata[37:6]));
            err_cnt++;
          end
          if (m_tlast !== e.last) begin
            $error("last_point exp %0b got %0b", e.last, m_tlast);
            err_cnt++;
          end
        end
      end
    end
  end

  task automatic reg_write(vas_pkg::reg_idx_t r, logic [31:0] d);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(r) << 2;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      vas_pkg::REG_BOUNDARY_MODE:  bnd_mode = d[0];
      vas_pkg::REG_BOUNDARY_VALUE: bnd_val  = longint'(signed'(d));
      vas_pkg::REG_VELOCITY_MODE:  vel_mode = d[0];
      vas_pkg::REG_LIN_VELOCITY:   lin_vel  = longint'(signed'(d));
      vas_pkg::REG_SCHEME_MODE:    sch_mode = d[0];
      vas_pkg::REG_RATIO_DT_DX:    dtdx     = longint'(signed'(d));
      vas_pkg::REG_DIFFUSION_COEF: dcoef    = longint'(signed'(d));
      default:                     lscale   = longint'(signed'(d));
    endcase
  endtask

  // Wait until all commands are taken and all points are out; a trailing load
  // may still be in flight, so keep clocking before returning.
  task automatic drain();
    @(negedge clk);
    while (cmd_q.size() > 0 || s_tvalid || point_q.size() > 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic push_cmd(bit k, int i, logic [31:0] v);
    grid_cmd_t c;
    c.kind = k;
    c.idx  = 6'(i);
    c.val  = v;
    cmd_q.push_back(c);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(3))
      0:       return $urandom();
      1:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'(int'($urandom_range(20 * 65536)) - 10 * 65536);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(5))
      0:       return $urandom();
      1:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($urandom_range(65536));
    endcase
  endfunction

  // Mostly loads with random content, an advance every eighth item or so.
  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(7) == 0) push_cmd(KIND_ADVANCE, $urandom_range(63), $urandom());
      else push_cmd(KIND_LOAD, $urandom_range(63), rand_sample());
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_arm = 1'b0;
    err_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    bnd_mode = 1; bnd_val = 0; vel_mode = 0; lin_vel = 655360;
    sch_mode = 0; dtdx = 65536; dcoef = 131; lscale = 65405;
    first_pending = 1'b1;
    for (int i = 0; i < GridPoints; i++) begin
      cur_f[i] = 0; prev_f[i] = 0; old_f[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: every point loaded (extremes at the ends and middle), then
    // periodic forward with reset registers.
    for (int i = 0; i < GridPoints; i++)
      push_cmd(KIND_LOAD, i, (i == 0 || i == 32) ? 32'h7fff_ffff :
               (i == 63 || i == 31) ? 32'h8000_0000 : 32'(int'(i * 4096) - 131072));
    push_cmd(KIND_ADVANCE, 0, '0);
    drain();

    // Fixed ends at the most negative value, leapfrog: three leapfrog steps, then a
    // reload rearms the forward step, and one more leapfrog step follows it.
    reg_write(vas_pkg::REG_BOUNDARY_MODE, 32'd0);
    reg_write(vas_pkg::REG_BOUNDARY_VALUE, 32'h8000_0000);
    reg_write(vas_pkg::REG_SCHEME_MODE, 32'd1);
    reg_write(vas_pkg::REG_LEAPFROG_SCALE, 32'd60000);
    push_cmd(KIND_ADVANCE, 63, 32'hffff_ffff);
    push_cmd(KIND_ADVANCE, 0, '0);
    push_cmd(KIND_ADVANCE, 0, '0);
    push_cmd(KIND_LOAD, 63, 32'h7fff_ffff);
    push_cmd(KIND_ADVANCE, 0, '0);
    push_cmd(KIND_ADVANCE, 0, '0);
    drain();

    // Local velocity, extreme coefficients, boundary at the positive limit.
    reg_write(vas_pkg::REG_VELOCITY_MODE, 32'd1);
    reg_write(vas_pkg::REG_BOUNDARY_VALUE, 32'h7fff_ffff);
    reg_write(vas_pkg::REG_LIN_VELOCITY, 32'h8000_0000);
    reg_write(vas_pkg::REG_RATIO_DT_DX, 32'h7fff_ffff);
    reg_write(vas_pkg::REG_DIFFUSION_COEF, 32'h8000_0000);
    push_cmd(KIND_ADVANCE, 0, '0);
    push_cmd(KIND_ADVANCE, 0, '0);
    drain();

    // Random phases, each with fresh registers and its own idling pattern.
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(vas_pkg::REG_BOUNDARY_MODE, $urandom_range(1));
      reg_write(vas_pkg::REG_BOUNDARY_VALUE, rand_sample());
      reg_write(vas_pkg::REG_VELOCITY_MODE, $urandom_range(1));
      reg_write(vas_pkg::REG_LIN_VELOCITY, rand_coef());
      reg_write(vas_pkg::REG_SCHEME_MODE, (ph == 0) ? 32'd1 : $urandom_range(1));
      reg_write(vas_pkg::REG_RATIO_DT_DX, rand_coef());
      reg_write(vas_pkg::REG_DIFFUSION_COEF, rand_coef());
      reg_write(vas_pkg::REG_LEAPFROG_SCALE, rand_coef());
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 54 : 20) : 0;
      recv_stall_pct = (ph == 2) ? 54 : ((ph == 3) ? 20 : 0);
      random_phase(95);
      if (ph == 0) begin
        // receiver holds off while the sender keeps offering
        @(posedge clk);
        hold_arm <= 1'b1;
        @(posedge clk);
        hold_arm <= 1'b0;
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (err_cnt == 0 && point_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (point_q.size() != 0) $error("%0d predicted points never came out", point_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
